[rtl/core/vfr_pkg.sv]
package vfr_pkg;

	// Field widths of the transaction channels
	localparam int OP_W    = 3;
	localparam int COUNT_W = 18;
	localparam int VOL_W   = 8;
	localparam int STAT_W  = 3;

	// Configuration register widths
	localparam int BPS_W  = 21;
	localparam int FADE_W = 15;
	localparam int REM_W  = FADE_W;

	// APB port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register indexes, taken from paddr[2]
	localparam logic REG_BPS  = 1'b0;
	localparam logic REG_FADE = 1'b1;

	// Reset values of the configuration registers
	localparam logic [BPS_W-1:0]  BPS_RESET  = 21'd176400;
	localparam logic [FADE_W-1:0] FADE_RESET = 15'd2000;

	// Milliseconds per second, used to scale byte counts
	localparam int MS_W = 10;
	localparam logic [MS_W-1:0] MS_PER_SEC = 10'd1000;

	typedef enum logic [OP_W-1:0] {
		OP_PLAY     = 3'd0,
		OP_FADE_OUT = 3'd1,
		OP_FADE_IN  = 3'd2,
		OP_CANCEL   = 3'd3,
		OP_MUTE     = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		MODE_IDLE        = 3'd0,
		MODE_OUT_PENDING = 3'd1,
		MODE_FADING_OUT  = 3'd2,
		MODE_IN_PENDING  = 3'd3,
		MODE_FADING_IN   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_MUL,
		ST_DIV2,
		ST_DONE
	} seq_state_t;

endpackage

[rtl/core/vfr_evt_if.sv]
interface vfr_evt_if
	import vfr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [COUNT_W-1:0] byte_count;
	logic [VOL_W-1:0]   current_volume;

	modport source(output valid, output operation, output byte_count, output current_volume,
		input ready);
	modport sink(input valid, input operation, input byte_count, input current_volume,
		output ready);
endinterface

[rtl/core/vfr_res_if.sv]
interface vfr_res_if
	import vfr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              volume_write;
	logic [VOL_W-1:0]  volume_value;
	logic [STAT_W-1:0] fade_status;
	logic              mute_on;

	modport source(output valid, output volume_write, output volume_value, output fade_status,
		output mute_on, input ready);
	modport sink(input valid, input volume_write, input volume_value, input fade_status,
		input mute_on, output ready);
endinterface

[rtl/core/vfr_div.sv]
// Restoring divider, two quotient bits per cycle.
module vfr_div
	import vfr_pkg::*;
#(
	parameter int DW  = 28,
	parameter int DVW = 21
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [DW-1:0]  quotient
);
	localparam int STEPS = DW / 2;
	localparam int CW    = $clog2(STEPS + 1);

	logic [DW-1:0]  num_q;
	logic [DVW:0]   rem_q;
	logic [DVW-1:0] dvs_q;
	logic [CW-1:0]  cnt_q;
	logic           done_q;

	logic [DVW:0] r1, r1n, r2, r2n;
	logic         ge1, ge2;

	// Two dependent compare-subtract steps
	always_comb begin
		r1  = {rem_q[DVW-1:0], num_q[DW-1]};
		ge1 = r1 >= {1'b0, dvs_q};
		r1n = ge1 ? (r1 - {1'b0, dvs_q}) : r1;
		r2  = {r1n[DVW-1:0], num_q[DW-2]};
		ge2 = r2 >= {1'b0, dvs_q};
		r2n = ge2 ? (r2 - {1'b0, dvs_q}) : r2;
	end

	// Load on start, then shift quotient bits in until the count runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[DW-3:0], ge1, ge2};
			rem_q <= r2n;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

[rtl/core/volume_fade_ramp_controller.sv]
// Channel  Dir  Fields                                          Handshake
// -------  ---  ----------------------------------------------  ------------
// evt      in   operation, byte_count, current_volume           valid/ready
// res      out  volume_write, volume_value, fade_status, mute_on valid/ready
// apb      in   bytes_per_second @0x0, fade_time_ms @0x4        psel/penable
//
// A played block during a fade runs one shared divider twice: elapsed ms
// (count*1000/rate) and the ramp volume (saved*remaining/fade_time). The
// second pass is started from ST_MUL and is skipped when the first pass ends
// the fade; every event then waits in ST_DONE to hand its result over. No new
// event is taken until the sequencer is back in ST_IDLE.
// Reset is asynchronous and clears the control and fade state, not the result data.
// A new event is taken while a finished result waits on res; the block
// stalls only when a second result is ready and res is still full.
module volume_fade_ramp_controller
	import vfr_pkg::*;
#(
	parameter int VOLUME_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	vfr_evt_if.sink           evt,
	vfr_res_if.source         res
);
	localparam int ProdW = VOLUME_BITS + REM_W;
	localparam int CntW  = COUNT_W + MS_W;
	localparam int RawW  = (ProdW > CntW) ? ProdW : CntW;
	localparam int DivW  = RawW + (RawW % 2);
	localparam int CapW  = (VOLUME_BITS < VOL_W) ? VOLUME_BITS : VOL_W;

	// Configuration registers
	logic [BPS_W-1:0]  bps_q;
	logic [FADE_W-1:0] fade_q;

	// Fade state
	seq_state_t             state_q, state_d;
	mode_t                  mode_q, mode_d;
	logic [REM_W-1:0]       rem_q, rem_d;
	logic [VOLUME_BITS-1:0] saved_q, saved_d;
	logic                   mute_q, mute_d;
	logic                   wr_q, wr_d;
	logic [VOLUME_BITS-1:0] val_q, val_d;

	// Output register
	logic                   out_valid_q;
	logic                   out_wr_q;
	logic [VOLUME_BITS-1:0] out_val_q;
	mode_t                  out_mode_q;
	logic                   out_mute_q;
	logic                   out_load;

	// Shared divider
	logic              div_start;
	logic [DivW-1:0]   div_dividend;
	logic [BPS_W-1:0]  div_divisor;
	logic              div_done;
	logic [DivW-1:0]   div_q;

	logic [CntW-1:0]        prod_ms;
	logic [ProdW-1:0]       prod_vol;
	logic [FADE_W-1:0]      fade_len;
	logic [BPS_W-1:0]       rate;
	logic [VOLUME_BITS-1:0] cap_vol;
	logic [VOLUME_BITS-1:0] ramp_t;
	logic                   ev_ready;

	// APB writes and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q  <= BPS_RESET;
			fade_q <= FADE_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_BPS:  bps_q  <= pwdata[BPS_W-1:0];
				REG_FADE: fade_q <= pwdata[FADE_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BPS:  prdata = APB_DW'(bps_q);
			REG_FADE: prdata = APB_DW'(fade_q);
			default:  prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Operands; a zero rate or fade time counts as one
	assign rate     = (bps_q == '0) ? BPS_W'(1) : bps_q;
	assign fade_len = (fade_q == '0) ? FADE_W'(1) : fade_q;
	assign prod_ms  = evt.byte_count * MS_PER_SEC;
	assign prod_vol = saved_q * rem_q;
	assign cap_vol  = VOLUME_BITS'(evt.current_volume[CapW-1:0]);
	assign ramp_t   = (div_q > DivW'(saved_q)) ? saved_q : div_q[VOLUME_BITS-1:0];

	vfr_div #(
		.DW (DivW),
		.DVW(BPS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_q)
	);

	// Sequencer: next state and register updates
	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		rem_d        = rem_q;
		saved_d      = saved_q;
		mute_d       = mute_q;
		wr_d         = wr_q;
		val_d        = val_q;
		div_start    = 1'b0;
		div_dividend = DivW'(prod_ms);
		div_divisor  = rate;
		ev_ready     = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ev_ready = 1'b1;
				if (evt.valid) begin
					wr_d    = 1'b0;
					val_d   = '0;
					state_d = ST_DONE;
					case (op_t'(evt.operation))
						OP_PLAY: begin
							if (mode_q == MODE_OUT_PENDING) begin
								saved_d   = cap_vol;
								mode_d    = MODE_FADING_OUT;
								rem_d     = fade_len;
								state_d   = ST_DIV1;
								div_start = 1'b1;
							end else if (mode_q == MODE_IN_PENDING) begin
								mode_d    = MODE_FADING_IN;
								rem_d     = fade_len;
								state_d   = ST_DIV1;
								div_start = 1'b1;
							end else if (mode_q inside {MODE_FADING_OUT, MODE_FADING_IN}) begin
								state_d   = ST_DIV1;
								div_start = 1'b1;
							end
						end
						OP_FADE_OUT: begin
							if (mode_q == MODE_IDLE) begin
								mode_d = MODE_OUT_PENDING;
							end
						end
						OP_FADE_IN: begin
							if (mode_q == MODE_IDLE && saved_q != '0) begin
								mode_d = MODE_IN_PENDING;
							end
						end
						OP_CANCEL: begin
							mute_d = 1'b0;
							mode_d = MODE_IDLE;
						end
						OP_MUTE: begin
							mute_d = 1'b1;
						end
						default: ;
					endcase
				end
			end
			// Shorten the remaining time; end the fade when it runs out
			ST_DIV1: begin
				if (div_done) begin
					wr_d = 1'b1;
					if (div_q >= DivW'(rem_q)) begin
						rem_d   = '0;
						mode_d  = MODE_IDLE;
						state_d = ST_DONE;
						if (mode_q == MODE_FADING_OUT) begin
							val_d = '0;
						end else begin
							val_d   = saved_q;
							saved_d = '0;
						end
					end else begin
						rem_d   = rem_q - div_q[REM_W-1:0];
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				div_start    = 1'b1;
				div_dividend = DivW'(prod_vol);
				div_divisor  = BPS_W'(fade_len);
				state_d      = ST_DIV2;
			end
			// Scale the saved volume by the remaining fraction; a fade-in takes the rest of it
			ST_DIV2: begin
				div_divisor = BPS_W'(fade_len);
				if (div_done) begin
					val_d   = (mode_q == MODE_FADING_OUT) ? ramp_t : (saved_q - ramp_t);
					state_d = ST_DONE;
				end
			end
			// Hand the result over once the output register is free
			ST_DONE: begin
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_IDLE;
			rem_q   <= '0;
			saved_q <= '0;
			mute_q  <= 1'b0;
			wr_q    <= 1'b0;
			val_q   <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			rem_q   <= rem_d;
			saved_q <= saved_d;
			mute_q  <= mute_d;
			wr_q    <= wr_d;
			val_q   <= val_d;
		end
	end

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_wr_q   <= wr_q;
			out_val_q  <= val_q;
			out_mode_q <= mode_q;
			out_mute_q <= mute_q;
		end
	end

	assign evt.ready        = ev_ready;
	assign res.valid        = out_valid_q;
	assign res.volume_write = out_wr_q;
	assign res.volume_value = VOL_W'(out_val_q);
	assign res.fade_status  = out_mode_q;
	assign res.mute_on      = out_mute_q;

endmodule

[tb/volume_fade_ramp_monitor.sv]
`timescale 1ns / 100ps

module volume_fade_ramp_monitor
	import vfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	vfr_evt_if                evt,
	vfr_res_if                res,
	output int                errors,
	output int                outstanding,
	output int                checked
);

	typedef struct packed {
		logic              vol_write;
		logic [VOL_W-1:0]  value;
		logic [STAT_W-1:0] status;
		logic              mute;
	} fade_result_t;

	// Shadow copy of the registers and the fade state
	logic [BPS_W-1:0]  rate_reg;
	logic [FADE_W-1:0] fade_reg;
	mode_t             mode;
	logic [REM_W-1:0]  remain_ms;
	logic [VOL_W-1:0]  saved_vol;
	logic              muted;

	fade_result_t expected_fades[$];

	// Zero fade time counts as one millisecond
	function automatic logic [31:0] fade_span();
		return (fade_reg == '0) ? 32'd1 : 32'(fade_reg);
	endfunction

	// Shorten the remaining time by one block; true once it reaches zero
	function automatic logic elapse(input logic [COUNT_W-1:0] count);
		logic [63:0] rate;
		logic [63:0] delta;
		rate = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
		delta = (64'(count) * MS_PER_SEC) / rate;
		if (delta >= 64'(remain_ms)) begin
			remain_ms = '0;
			return 1'b1;
		end
		remain_ms = remain_ms - REM_W'(delta);
		return 1'b0;
	endfunction

	// Advance the fade state by one event and form the result it causes
	function automatic fade_result_t predict_fade_step(input logic [OP_W-1:0] op,
			input logic [COUNT_W-1:0] count, input logic [VOL_W-1:0] vol);
		fade_result_t r;
		logic         ended;
		logic [63:0]  ramp;
		r = '0;
		case (op)
			OP_PLAY: begin
				if (mode == MODE_OUT_PENDING) begin
					saved_vol = vol;
					mode = MODE_FADING_OUT;
					remain_ms = REM_W'(fade_span());
				end
				if (mode == MODE_FADING_OUT) begin
					ended = elapse(count);
					ramp = (64'(saved_vol) * remain_ms) / fade_span();
					if (ramp > 64'(saved_vol))
						ramp = 64'(saved_vol);
					r.value = ended ? '0 : ramp[VOL_W-1:0];
					if (ended)
						mode = MODE_IDLE;
					r.vol_write = 1'b1;
				end else begin
					if (mode == MODE_IN_PENDING) begin
						remain_ms = REM_W'(fade_span());
						mode = MODE_FADING_IN;
					end
					if (mode == MODE_FADING_IN) begin
						ended = elapse(count);
						ramp = (64'(remain_ms) * saved_vol) / fade_span();
						if (ramp > 64'(saved_vol))
							ramp = 64'(saved_vol);
						r.value = saved_vol - ramp[VOL_W-1:0];
						if (ended) begin
							mode = MODE_IDLE;
							r.value = saved_vol;
							saved_vol = '0;
						end
						r.vol_write = 1'b1;
					end
				end
			end
			OP_FADE_OUT: begin
				if (mode == MODE_IDLE)
					mode = MODE_OUT_PENDING;
			end
			OP_FADE_IN: begin
				if (mode == MODE_IDLE && saved_vol != '0)
					mode = MODE_IN_PENDING;
			end
			OP_CANCEL: begin
				muted = 1'b0;
				mode = MODE_IDLE;
			end
			OP_MUTE: begin
				muted = 1'b1;
			end
			default: begin
			end
		endcase
		r.status = mode;
		r.mute = muted;
		return r;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// Track register writes, check results, queue predictions
	always @(posedge clk or negedge arst_n) begin
		fade_result_t want;
		if (!arst_n) begin
			rate_reg = BPS_RESET;
			fade_reg = FADE_RESET;
			mode = MODE_IDLE;
			remain_ms = '0;
			saved_vol = '0;
			muted = 1'b0;
			expected_fades.delete();
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_BPS)
					rate_reg = pwdata[BPS_W-1:0];
				else
					fade_reg = pwdata[FADE_W-1:0];
			end
			if (res.valid && res.ready) begin
				checked++;
				if (expected_fades.size() == 0) begin
					$error("result transaction with no event outstanding");
					errors++;
				end else begin
					want = expected_fades.pop_front();
					compare_field("volume_write", want.vol_write, res.volume_write);
					compare_field("volume_value", want.value, res.volume_value);
					compare_field("fade_status", want.status, res.fade_status);
					compare_field("mute_on", want.mute, res.mute_on);
				end
			end
			if (evt.valid && evt.ready)
				expected_fades.push_back(predict_fade_step(evt.operation, evt.byte_count,
					evt.current_volume));
			outstanding = expected_fades.size();
		end
	end

endmodule

[tb/volume_fade_ramp_controller_tb.sv]
`timescale 1ns / 100ps

module volume_fade_ramp_controller_tb;
	import vfr_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 4;
	localparam int SETTLE_CYCLES   = 100;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_PHASE      = 4;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int BLOCK_MAX       = 131072;
	localparam int RATE_MAX        = 1536000;
	localparam int FADE_MAX        = 32767;

	// Operation codes the block must ignore
	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	vfr_evt_if evt_bus();
	vfr_res_if res_bus();

	int monitor_errors;
	int fades_outstanding;
	int results_checked;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_cycles    = 0;
	int events_sent    = 0;
	int reg_writes     = 0;
	bit drain_failed;

	logic [BPS_W-1:0]  rate_now;
	logic [FADE_W-1:0] fade_now;

	volume_fade_ramp_controller #(
		.VOLUME_BITS(VOL_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.evt(evt_bus),
		.res(res_bus)
	);

	volume_fade_ramp_monitor monitor (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.evt(evt_bus),
		.res(res_bus),
		.errors(monitor_errors),
		.outstanding(fades_outstanding),
		.checked(results_checked)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Drive result ready: honor a requested hold-off first, else stall at random
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_bus.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offer one event after a random gap and hold it until accepted
	task automatic send_event(input logic [OP_W-1:0] op, input int count, input int vol);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			evt_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_bus.valid <= 1'b1;
		evt_bus.operation <= op;
		evt_bus.byte_count <= COUNT_W'(count);
		evt_bus.current_volume <= VOL_W'(vol);
		@(posedge clk);
		while (!evt_bus.ready)
			@(posedge clk);
		events_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every result has come back
	task automatic wait_drained();
		evt_bus.valid <= 1'b0;
		@(negedge clk);
		while (fades_outstanding != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic apply_setting(input int rate, input int fade);
		apb_write(REG_BPS, rate);
		apb_write(REG_FADE, fade);
		rate_now = BPS_W'(rate);
		fade_now = FADE_W'(fade);
	endtask

	// Change idle pattern away from the falling edge the receiver samples on
	task automatic set_pattern(input int pattern, input int hold);
		@(posedge clk);
		case (pattern)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
			default: begin send_idle_pct = 16; recv_stall_pct = 16; end
		endcase
		hold_cycles = hold;
		@(negedge clk);
	endtask

	// Block sizes scaled so a fade takes a few blocks at the current setting
	function automatic int pick_count();
		longint span;
		int     rate_eff;
		int     fade_eff;
		rate_eff = (rate_now == '0) ? 1 : int'(rate_now);
		fade_eff = (fade_now == '0) ? 1 : int'(fade_now);
		span = longint'(rate_eff) * longint'(fade_eff) / 1000 / 3;
		if (span < 1)
			span = 1;
		if (span > BLOCK_MAX)
			span = BLOCK_MAX;
		if ($urandom_range(99) < 85)
			return $urandom_range(0, int'(span));
		return $urandom_range(0, BLOCK_MAX);
	endfunction

	function automatic int pick_volume();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 255;
		if (r < 20)
			return 0;
		return $urandom_range(0, 255);
	endfunction

	// Mostly full fade-out / fade-in sequences, the rest loose events
	task automatic run_random(input int quota);
		int n;
		logic [OP_W-1:0] op;
		n = 0;
		while (n < quota) begin
			if ($urandom_range(99) < 70) begin
				send_event(OP_FADE_OUT, pick_count(), pick_volume());
				n++;
				repeat ($urandom_range(1, 8)) begin
					send_event(OP_PLAY, pick_count(), pick_volume());
					n++;
				end
				if ($urandom_range(99) < 75) begin
					send_event(OP_FADE_IN, pick_count(), pick_volume());
					n++;
					repeat ($urandom_range(1, 8)) begin
						send_event(OP_PLAY, pick_count(), pick_volume());
						n++;
					end
				end
				if ($urandom_range(99) < 20) begin
					send_event(OP_CANCEL, pick_count(), pick_volume());
					n++;
				end
			end else begin
				op = OP_W'($urandom_range(0, 7));
				send_event(op, $urandom_range(0, BLOCK_MAX), $urandom_range(0, 255));
				if (op <= OP_MUTE)
					n++;
			end
		end
	endtask

	// Walk every operation and the corner cases at reset settings
	task automatic run_directed();
		send_event(OP_PLAY, BLOCK_MAX, 255);
		send_event(OP_FADE_IN, 0, 0);
		send_event(OP_RSVD_5, BLOCK_MAX, 255);
		send_event(OP_RSVD_6, 0, 0);
		send_event(OP_RSVD_7, 1, 1);
		send_event(OP_MUTE, 0, 0);
		send_event(OP_FADE_OUT, 0, 0);
		send_event(OP_FADE_OUT, 0, 0);
		send_event(OP_FADE_IN, 0, 0);
		send_event(OP_PLAY, 0, 255);
		send_event(OP_PLAY, 17640, 0);
		send_event(OP_PLAY, BLOCK_MAX, 0);
		send_event(OP_PLAY, BLOCK_MAX, 0);
		send_event(OP_PLAY, BLOCK_MAX, 0);
		send_event(OP_FADE_IN, 0, 0);
		send_event(OP_PLAY, 35280, 0);
		send_event(OP_PLAY, BLOCK_MAX, 0);
		send_event(OP_PLAY, BLOCK_MAX, 0);
		send_event(OP_PLAY, BLOCK_MAX, 0);
		send_event(OP_CANCEL, 0, 0);
		send_event(OP_FADE_OUT, 0, 0);
		send_event(OP_PLAY, 0, 200);
		send_event(OP_CANCEL, 0, 0);
		send_event(OP_FADE_IN, 0, 0);
		send_event(OP_PLAY, BLOCK_MAX, 0);
	endtask

	initial begin
		int phase;
		int cycles;
		int rate;
		int fade;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_bus.valid = 1'b0;
		evt_bus.operation = OP_PLAY;
		evt_bus.byte_count = '0;
		evt_bus.current_volume = '0;
		rate_now = BPS_RESET;
		fade_now = FADE_RESET;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();

		// Each phase: drain, reprogram, pick a handshake pattern, run random events
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: begin rate = int'(BPS_RESET); fade = int'(FADE_RESET); end
				1: begin rate = 1; fade = 1; end
				2: begin rate = RATE_MAX; fade = FADE_MAX; end
				3: begin rate = 0; fade = 0; end
				4: begin rate = 48000; fade = 250; end
				6: begin rate = 8000; fade = FADE_MAX; end
				default: begin
					rate = $urandom_range(1, RATE_MAX);
					fade = $urandom_range(1, FADE_MAX);
				end
			endcase
			apply_setting(rate, fade);
			set_pattern(phase % 4, (phase == HOLD_PHASE) ? HOLD_OFF_CYCLES : 0);
			run_random(ITEMS_PER_PHASE);
		end

		// Drain with a bound, then let the block settle
		evt_bus.valid <= 1'b0;
		cycles = 0;
		@(negedge clk);
		while (fades_outstanding != 0 && cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			cycles++;
		end
		drain_failed = (fades_outstanding != 0);
		if (drain_failed)
			$error("%0d results never arrived", fades_outstanding);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d events, %0d register writes over %0d settings, four patterns,",
			events_sent, reg_writes, NUM_PHASES + 1);
		$display("a %0d-cycle result hold-off and full drains; %0d results compared",
			HOLD_OFF_CYCLES, results_checked);
		if (monitor_errors == 0 && !drain_failed)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/vfr_pkg.sv
rtl/core/vfr_evt_if.sv
rtl/core/vfr_res_if.sv
rtl/core/vfr_div.sv
rtl/core/volume_fade_ramp_controller.sv
tb/volume_fade_ramp_monitor.sv
tb/volume_fade_ramp_controller_tb.sv
